### hdl/aqsts_pkg.sv
`default_nettype none

package aqsts_pkg;

    localparam int STEPS      = 16;
    localparam int CHANNELS   = 4;
    localparam int ARM_INPUTS = 4;

    localparam int SAMPLE_W  = 15;
    localparam int TICKS_W   = 16;
    localparam int LIGHTS_W  = 4;
    localparam int STEP_OUT_W = 5;
    localparam int STEP_W    = $clog2(STEPS + 1);
    localparam int QUARTER_W = STEP_W - 2;
    localparam int CFG_IDX_W = 4;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_GATE_MODE   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_PULSE_TICKS = CFG_IDX_W'(1);

    localparam logic [TICKS_W-1:0] PULSE_TICKS_RESET = TICKS_W'(48);

    localparam logic signed [SAMPLE_W-1:0] RISE_MV = 15'sd1000;
    localparam logic signed [SAMPLE_W-1:0] FALL_MV = 15'sd0;

    typedef struct packed {
        logic level;
        logic rise;
    } trig_t;

    // sequencer decisions for one tick
    typedef struct packed {
        logic                 reset_edge;
        logic                 clock_edge;
        logic                 quarter_hit;
        logic [QUARTER_W-1:0] quarter;
    } seq_ctl_t;

    // what one lane needs for one tick
    typedef struct packed {
        logic               upd;
        logic               reset_edge;
        logic               fire;
        logic               close;
        logic               gate_mode;
        logic [TICKS_W-1:0] pulse_ticks;
    } lane_ctl_t;

    function automatic trig_t schmitt(input logic level,
                                      input logic signed [SAMPLE_W-1:0] mv);
        trig_t r;
        r.level = level;
        r.rise  = 1'b0;
        if (level)
        begin
            if (mv <= FALL_MV)
            begin
                r.level = 1'b0;
            end
        end
        else if (mv >= RISE_MV)
        begin
            r.level = 1'b1;
            r.rise  = 1'b1;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### hdl/aqsts_if.sv
`default_nettype none

interface aqsts_in_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [aqsts_pkg::SAMPLE_W-1:0]  clock_sample;
    logic                                   clock_connected;
    logic signed [aqsts_pkg::SAMPLE_W-1:0]  reset_sample;
    logic                                   reset_connected;
    logic signed [aqsts_pkg::SAMPLE_W-1:0]  arm_sample_0;
    logic signed [aqsts_pkg::SAMPLE_W-1:0]  arm_sample_1;
    logic signed [aqsts_pkg::SAMPLE_W-1:0]  arm_sample_2;
    logic signed [aqsts_pkg::SAMPLE_W-1:0]  arm_sample_3;
    logic [aqsts_pkg::ARM_INPUTS-1:0]       arm_buttons;

    modport source (output valid, clock_sample, clock_connected, reset_sample,
                    reset_connected, arm_sample_0, arm_sample_1, arm_sample_2,
                    arm_sample_3, arm_buttons, input ready);
    modport sink (input valid, clock_sample, clock_connected, reset_sample,
                  reset_connected, arm_sample_0, arm_sample_1, arm_sample_2,
                  arm_sample_3, arm_buttons, output ready);
endinterface

interface aqsts_out_if;
    logic                                 valid;
    logic                                 ready;
    logic [aqsts_pkg::LIGHTS_W-1:0]       gate_out;
    logic [aqsts_pkg::LIGHTS_W-1:0]       armed_lights;
    logic [aqsts_pkg::STEP_OUT_W-1:0]     step_now;

    modport source (output valid, gate_out, armed_lights, step_now, input ready);
    modport sink (input valid, gate_out, armed_lights, step_now, output ready);
endinterface

interface aqsts_cfg_if;
    logic                                 valid;
    logic                                 ready;
    logic [aqsts_pkg::CFG_IDX_W-1:0]      index;
    logic [aqsts_pkg::CFG_DATA_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

### hdl/armed_quarter_step_trigger_sequencer_unit.sv
// A result word is registered when its tick is accepted. Throughput: one tick
// per cycle while ready is high; all lanes and the step counter update in the
// accept cycle. A two-deep output buffer keeps input ready while one word waits.
// Reset (rst_n low, asynchronous): step 0, armed, gate and pulse counts clear,
// all triggers high, gate_mode 0, pulse_ticks 48, output buffer empty.
`default_nettype none

module armed_quarter_step_trigger_sequencer_unit (
    input  wire logic    clk,
    input  wire logic    rst_n,
    aqsts_in_if.sink     in_ch,
    aqsts_out_if.source  out_ch,
    aqsts_cfg_if.sink    cfg
);

    logic                               accept;
    logic                               in_ready;
    logic                               gate_mode_reg;
    logic [aqsts_pkg::TICKS_W-1:0]      pulse_ticks_reg;
    aqsts_pkg::seq_ctl_t                seq;
    logic [aqsts_pkg::STEP_W-1:0]       step_next;
    logic [aqsts_pkg::STEP_W-1:0]       step_q;
    logic [aqsts_pkg::CHANNELS-1:0]     lane_gates;
    logic [aqsts_pkg::CHANNELS-1:0]     lane_armed;
    logic signed [aqsts_pkg::SAMPLE_W-1:0] arm_mv [aqsts_pkg::ARM_INPUTS];

    assign in_ch.ready = in_ready;
    assign accept      = in_ch.valid && in_ready;
    assign cfg.ready   = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gate_mode_reg   <= 1'b0;
            pulse_ticks_reg <= aqsts_pkg::PULSE_TICKS_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                aqsts_pkg::REG_GATE_MODE:
                begin
                    gate_mode_reg <= cfg.data[0];
                end
                aqsts_pkg::REG_PULSE_TICKS:
                begin
                    pulse_ticks_reg <= cfg.data[aqsts_pkg::TICKS_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    aqsts_clock u_clock (
        .clk             (clk),
        .rst_n           (rst_n),
        .upd             (accept),
        .clock_sample    (in_ch.clock_sample),
        .clock_connected (in_ch.clock_connected),
        .reset_sample    (in_ch.reset_sample),
        .reset_connected (in_ch.reset_connected),
        .ctl             (seq),
        .step_next       (step_next),
        .step_q          (step_q)
    );

    assign arm_mv[0] = in_ch.arm_sample_0;
    assign arm_mv[1] = in_ch.arm_sample_1;
    assign arm_mv[2] = in_ch.arm_sample_2;
    assign arm_mv[3] = in_ch.arm_sample_3;

    for (genvar i = 0; i < aqsts_pkg::CHANNELS; i++)
    begin : g_lane
        aqsts_pkg::lane_ctl_t                  lctl;
        logic signed [aqsts_pkg::SAMPLE_W-1:0] mv;
        logic                                  btn;

        // previous channel of quarter 0 is the last one
        assign lctl.upd         = accept;
        assign lctl.reset_edge  = seq.reset_edge;
        assign lctl.fire        = seq.quarter_hit && (32'(seq.quarter) == i);
        assign lctl.close       = seq.quarter_hit &&
                                  ((32'(seq.quarter) == i + 1) ||
                                   ((i == aqsts_pkg::CHANNELS - 1) && (seq.quarter == '0)));
        assign lctl.gate_mode   = gate_mode_reg;
        assign lctl.pulse_ticks = pulse_ticks_reg;

        if (i < aqsts_pkg::ARM_INPUTS)
        begin : g_arm
            assign mv  = arm_mv[i];
            assign btn = in_ch.arm_buttons[i];
        end
        else
        begin : g_noarm
            assign mv  = '0;
            assign btn = 1'b0;
        end

        aqsts_lane u_lane (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl        (lctl),
            .arm_mv     (mv),
            .arm_button (btn),
            .gate_bit   (lane_gates[i]),
            .armed_bit  (lane_armed[i])
        );
    end

    aqsts_merge u_merge (
        .clk        (clk),
        .rst_n      (rst_n),
        .upd        (accept),
        .lane_gates (lane_gates),
        .lane_armed (lane_armed),
        .step       (step_next),
        .in_ready   (in_ready),
        .out_ch     (out_ch)
    );

    a_ready_needs_word: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_ch.valid)
        else $error("input stalled with no word on the output");

    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        step_q <= aqsts_pkg::STEP_W'(aqsts_pkg::STEPS))
        else $error("step out of range");

    a_reset_step: assert property (@(posedge clk) disable iff (!rst_n)
        accept && seq.reset_edge && !seq.clock_edge
        |=> step_q == aqsts_pkg::STEP_W'(aqsts_pkg::STEPS))
        else $error("reset edge did not park the step");

    a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> out_ch.valid)
        else $error("accepted tick produced no word");

endmodule

`default_nettype wire

### hdl/aqsts_clock.sv
`default_nettype none

module aqsts_clock (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  upd,
    input  wire logic signed [aqsts_pkg::SAMPLE_W-1:0] clock_sample,
    input  wire logic                                  clock_connected,
    input  wire logic signed [aqsts_pkg::SAMPLE_W-1:0] reset_sample,
    input  wire logic                                  reset_connected,
    output aqsts_pkg::seq_ctl_t                        ctl,
    output logic [aqsts_pkg::STEP_W-1:0]               step_next,
    output logic [aqsts_pkg::STEP_W-1:0]               step_q
);

    logic                          clk_trig_reg;
    logic                          clk_trig_next;
    logic                          rst_trig_reg;
    logic                          rst_trig_next;
    logic [aqsts_pkg::STEP_W-1:0]  step_reg;

    always_comb
    begin
        aqsts_pkg::trig_t            rt;
        aqsts_pkg::trig_t            ct;
        logic [aqsts_pkg::STEP_W:0]  inc;
        logic [aqsts_pkg::STEP_W-1:0] s;

        rt = aqsts_pkg::schmitt(rst_trig_reg, reset_sample);
        ct = aqsts_pkg::schmitt(clk_trig_reg, clock_sample);
        if (!reset_connected)
        begin
            rt.level = rst_trig_reg;
            rt.rise  = 1'b0;
        end
        if (!clock_connected)
        begin
            ct.level = clk_trig_reg;
            ct.rise  = 1'b0;
        end
        rst_trig_next = rt.level;
        clk_trig_next = ct.level;

        s   = rt.rise ? aqsts_pkg::STEP_W'(aqsts_pkg::STEPS) : step_reg;
        inc = {1'b0, s} + 1'b1;
        if (ct.rise)
        begin
            if (inc >= (aqsts_pkg::STEP_W + 1)'(aqsts_pkg::STEPS))
            begin
                s = '0;
            end
            else
            begin
                s = inc[aqsts_pkg::STEP_W-1:0];
            end
        end
        step_next = s;

        ctl.reset_edge  = rt.rise;
        ctl.clock_edge  = ct.rise;
        ctl.quarter_hit = ct.rise && (s[1:0] == 2'b00);
        ctl.quarter     = s[aqsts_pkg::STEP_W-1:2];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clk_trig_reg <= 1'b1;
            rst_trig_reg <= 1'b1;
            step_reg     <= '0;
        end
        else if (upd)
        begin
            clk_trig_reg <= clk_trig_next;
            rst_trig_reg <= rst_trig_next;
            step_reg     <= step_next;
        end
    end

    assign step_q = step_reg;

endmodule

`default_nettype wire

### hdl/aqsts_lane.sv
`default_nettype none

module aqsts_lane (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire aqsts_pkg::lane_ctl_t                  ctl,
    input  wire logic signed [aqsts_pkg::SAMPLE_W-1:0] arm_mv,
    input  wire logic                                  arm_button,
    output logic                                       gate_bit,
    output logic                                       armed_bit
);

    logic                           trig_reg;
    logic                           trig_next;
    logic                           armed_reg;
    logic                           armed_next;
    logic                           gate_reg;
    logic                           gate_next;
    logic [aqsts_pkg::TICKS_W-1:0]  pulse_reg;
    logic [aqsts_pkg::TICKS_W-1:0]  pulse_next;

    always_comb
    begin
        aqsts_pkg::trig_t              at;
        logic                          armed1;
        logic                          gate1;
        logic [aqsts_pkg::TICKS_W-1:0] pulse1;
        logic                          active;

        armed1 = ctl.reset_edge ? 1'b0 : armed_reg;
        gate1  = ctl.reset_edge ? 1'b0 : gate_reg;
        pulse1 = pulse_reg;

        if (ctl.close)
        begin
            gate1 = 1'b0;
        end
        if (ctl.fire && armed1)
        begin
            if (pulse_reg < ctl.pulse_ticks)
            begin
                pulse1 = ctl.pulse_ticks;
            end
            if (ctl.gate_mode)
            begin
                gate1 = 1'b1;
            end
            armed1 = 1'b0;
        end

        at = aqsts_pkg::schmitt(ctl.reset_edge | trig_reg, arm_mv);
        trig_next  = at.level;
        armed_next = armed1 | arm_button | at.rise;
        gate_next  = gate1;

        active     = (pulse1 != '0);
        pulse_next = active ? pulse1 - 1'b1 : pulse1;

        gate_bit  = active | gate1;
        armed_bit = armed_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trig_reg  <= 1'b1;
            armed_reg <= 1'b0;
            gate_reg  <= 1'b0;
            pulse_reg <= '0;
        end
        else if (ctl.upd)
        begin
            trig_reg  <= trig_next;
            armed_reg <= armed_next;
            gate_reg  <= gate_next;
            pulse_reg <= pulse_next;
        end
    end

endmodule

`default_nettype wire

### hdl/aqsts_merge.sv
`default_nettype none

// gathers lane results into one word, two-deep output buffer
module aqsts_merge (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                upd,
    input  wire logic [aqsts_pkg::CHANNELS-1:0]      lane_gates,
    input  wire logic [aqsts_pkg::CHANNELS-1:0]      lane_armed,
    input  wire logic [aqsts_pkg::STEP_W-1:0]        step,
    output logic                                     in_ready,
    aqsts_out_if.source                              out_ch
);

    typedef struct packed {
        logic [aqsts_pkg::LIGHTS_W-1:0]   gates;
        logic [aqsts_pkg::LIGHTS_W-1:0]   lights;
        logic [aqsts_pkg::STEP_OUT_W-1:0] step;
    } word_t;

    word_t word_new;
    word_t out_reg;
    word_t skid_reg;
    logic  out_valid_reg;
    logic  skid_valid_reg;
    logic [aqsts_pkg::STEP_W+aqsts_pkg::STEP_OUT_W-1:0] step_ext;

    for (genvar j = 0; j < aqsts_pkg::LIGHTS_W; j++)
    begin : g_pack
        if (j < aqsts_pkg::CHANNELS)
        begin : g_lane
            assign word_new.gates[j]  = lane_gates[j];
            assign word_new.lights[j] = lane_armed[j];
        end
        else
        begin : g_none
            assign word_new.gates[j]  = 1'b0;
            assign word_new.lights[j] = 1'b0;
        end
    end

    assign step_ext      = (aqsts_pkg::STEP_W + aqsts_pkg::STEP_OUT_W)'(step);
    assign word_new.step = step_ext[aqsts_pkg::STEP_OUT_W-1:0];

    assign in_ready = !skid_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_valid_reg && !out_ch.ready)
        begin
            if (upd)
            begin
                skid_reg       <= word_new;
                skid_valid_reg <= 1'b1;
            end
        end
        else if (skid_valid_reg)
        begin
            out_reg        <= skid_reg;
            out_valid_reg  <= 1'b1;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= upd;
            if (upd)
            begin
                out_reg <= word_new;
            end
        end
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.gate_out     = out_reg.gates;
    assign out_ch.armed_lights = out_reg.lights;
    assign out_ch.step_now     = out_reg.step;

endmodule

`default_nettype wire
